>>> hw/rtl/upc_pkg.sv
// Shared types and constants for the upload path census block.
`default_nettype none

package upc_pkg;

  localparam logic [31:0] DIM_MAX = 32'd32768;

  typedef enum logic [2:0] {
    CLS_REJECT = 3'd0,
    CLS_FAST   = 3'd1,
    CLS_NPOT   = 3'd2,
    CLS_FORMAT = 3'd3,
    CLS_BOTH   = 3'd4
  } path_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } census_state_t;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] dst;
    logic [31:0] src;
  } combo_t;

  typedef struct packed {
    logic tok;
    logic hit;
  } link_t;

endpackage

`default_nettype wire

>>> hw/rtl/upc_if.sv
// Handshake interfaces for the upload word and the census result word.
`default_nettype none

interface upc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] width;
  logic signed [31:0] height;
  logic signed [31:0] dst_format;
  logic signed [31:0] src_format;

  modport source (output valid, output width, output height, output dst_format,
                  output src_format, input ready);
  modport sink (input valid, input width, input height, input dst_format,
                input src_format, output ready);
endinterface

interface upc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  path_class;
  logic        new_combo;
  logic        combo_dropped;
  logic [31:0] total_count;
  logic [31:0] fast_count;
  logic [31:0] npot_count;
  logic [31:0] format_count;
  logic [31:0] both_count;
  logic [5:0]  distinct_count;

  modport source (output valid, output path_class, output new_combo,
                  output combo_dropped, output total_count, output fast_count,
                  output npot_count, output format_count, output both_count,
                  output distinct_count, input ready);
  modport sink (input valid, input path_class, input new_combo,
                input combo_dropped, input total_count, input fast_count,
                input npot_count, input format_count, input both_count,
                input distinct_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/upc_classify.sv
// Classifies one upload by its dimensions and formats.
`default_nettype none

module upc_classify import upc_pkg::*; (
  input  logic [31:0] w,
  input  logic [31:0] h,
  input  logic [31:0] dst,
  input  logic [31:0] src,
  output path_class_t cls
);

  logic dim_ok;
  logic npot;
  logic fmt;

  assign dim_ok = (w >= 32'd1) && (w <= DIM_MAX) && (h >= 32'd1) && (h <= DIM_MAX);
  assign npot   = ((w & (w - 32'd1)) != 32'd0) || ((h & (h - 32'd1)) != 32'd0);
  assign fmt    = (dst != src);

  always_comb begin
    if (!dim_ok) begin
      cls = CLS_REJECT;
    end else if (!npot && !fmt) begin
      cls = CLS_FAST;
    end else if (npot && fmt) begin
      cls = CLS_BOTH;
    end else if (npot) begin
      cls = CLS_NPOT;
    end else begin
      cls = CLS_FORMAT;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/upc_cell.sv
// One table cell: holds a stored combination and passes the search token on.
`default_nettype none

module upc_cell import upc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  combo_t key,
  input  logic   wr_en,
  input  logic   occupied,
  input  link_t  link_in,
  output link_t  link_out
);

  combo_t entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else begin
      link_out.tok <= link_in.tok;
      link_out.hit <= link_in.hit | (link_in.tok & occupied & (entry == key));
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/upload_path_census.sv
// Top level of the upload path census: classification, counters and the combination table.
// Each accepted upload word is classified, counted unless rejected and, when slow, looked
// up in a row of TABLE_DEPTH cells that each hold one distinct slow combination. A search
// token enters the first cell in the cycle after the word is taken and moves one cell per
// cycle; when it leaves the last cell the scan ends. A fast or rejected upload needs no
// scan. One upload is in work at a time; a finished result word waits in an output
// register while the next upload is taken and processed. The table contents need no
// clearing after reset; only the fill count and the token chain are reset.
`default_nettype none

module upload_path_census import upc_pkg::*; #(
  parameter int TABLE_DEPTH = 48
) (
  input  logic      clk,
  input  logic      rst,
  upc_in_if.sink    upload,
  upc_out_if.source result
);

  localparam int FW = $clog2(TABLE_DEPTH + 1);

  census_state_t state;
  census_state_t state_next;

  path_class_t in_cls;
  path_class_t item_cls;
  combo_t      key;
  logic        launch;
  logic        accept;
  logic        slow_in;
  logic        append;
  logic        scan_end;
  logic        room;
  logic        leave_done;
  logic        item_new;
  logic        item_drop;

  logic [FW-1:0] fill;
  logic [31:0]   total_counter;
  logic [31:0]   fast_counter;
  logic [31:0]   npot_counter;
  logic [31:0]   format_counter;
  logic [31:0]   both_counter;

  link_t                  links [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] wr_sel;
  logic [TABLE_DEPTH-1:0] occ;

  upc_classify u_classify (
    .w   (upload.width),
    .h   (upload.height),
    .dst (upload.dst_format),
    .src (upload.src_format),
    .cls (in_cls)
  );

  assign slow_in    = (in_cls != CLS_REJECT) && (in_cls != CLS_FAST);
  assign accept     = upload.valid & upload.ready;
  assign room       = (fill != FW'(TABLE_DEPTH));
  assign scan_end   = (state == ST_SCAN) && links[TABLE_DEPTH].tok;

  always_comb begin
    case (state)
      ST_IDLE: begin
        if (upload.valid) begin
          state_next = slow_in ? ST_SCAN : ST_DONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        state_next = links[TABLE_DEPTH].tok ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        state_next = (!result.valid || result.ready) ? ST_IDLE : ST_DONE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    upload.ready = (state == ST_IDLE) && !rst;
    append       = scan_end && !links[TABLE_DEPTH].hit && room;
    leave_done   = (state == ST_DONE) && (!result.valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign links[0] = '{tok: launch, hit: 1'b0};

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occ[i]    = (fill > FW'(i));
    assign wr_sel[i] = append && (fill == FW'(i));

    upc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .wr_en    (wr_sel[i]),
      .occupied (occ[i]),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= '{w: upload.width, h: upload.height,
                    dst: upload.dst_format, src: upload.src_format};
      item_cls <= in_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch         <= 1'b0;
      fill           <= '0;
      item_new       <= 1'b0;
      item_drop      <= 1'b0;
      total_counter  <= '0;
      fast_counter   <= '0;
      npot_counter   <= '0;
      format_counter <= '0;
      both_counter   <= '0;
    end else begin
      launch <= accept && slow_in;
      if (accept) begin
        item_new  <= 1'b0;
        item_drop <= 1'b0;
        if (in_cls != CLS_REJECT) begin
          total_counter <= total_counter + 32'd1;
        end
        case (in_cls)
          CLS_FAST:   fast_counter   <= fast_counter + 32'd1;
          CLS_NPOT:   npot_counter   <= npot_counter + 32'd1;
          CLS_FORMAT: format_counter <= format_counter + 32'd1;
          CLS_BOTH:   both_counter   <= both_counter + 32'd1;
          default: begin
          end
        endcase
      end
      if (scan_end) begin
        item_new  <= append;
        item_drop <= !links[TABLE_DEPTH].hit && !room;
      end
      if (append) begin
        fill <= fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (leave_done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leave_done) begin
      result.path_class     <= item_cls;
      result.new_combo      <= item_new;
      result.combo_dropped  <= item_drop;
      result.total_count    <= total_counter;
      result.fast_count     <= fast_counter;
      result.npot_count     <= npot_counter;
      result.format_count   <= format_counter;
      result.both_count     <= both_counter;
      result.distinct_count <= 6'(fill);
    end
  end

endmodule

`default_nettype wire
